### rtl/pnl_pkg.sv
// Package for the periodic neighbour list builder.
// Sizes, op, status and register codes, shared types. No dependencies.
package pnl_pkg;

    localparam int MAX_ATOMS  = 64;
    localparam int COORD_BITS = 20;
    localparam int CFG_W      = 20;
    localparam int ID_W       = 20;
    localparam int SLOT_W     = $clog2(MAX_ATOMS);
    localparam int CNT_W      = $clog2(MAX_ATOMS + 1);
    localparam int V_W        = (COORD_BITS > CFG_W) ? COORD_BITS : CFG_W;
    localparam int D_W        = V_W + 2;
    localparam int M_W        = V_W + 1;
    localparam int SQ_W       = 2 * M_W;
    localparam int SUM_W      = SQ_W + 2;
    localparam int LIM_W      = 2 * CFG_W;
    localparam int OP_W       = 2;
    localparam int ST_W       = 3;
    localparam int CIDX_W     = 2;

    typedef logic [OP_W-1:0]         t_op;
    typedef logic [ST_W-1:0]         t_status;
    typedef logic [ID_W-1:0]         t_id;
    typedef logic [COORD_BITS-1:0]   t_coord;
    typedef logic [SLOT_W-1:0]       t_slot;
    typedef logic [CNT_W-1:0]        t_cnt;
    typedef logic [CFG_W-1:0]        t_cfg;
    typedef logic [CIDX_W-1:0]       t_cidx;
    typedef logic [2:0][COORD_BITS-1:0] t_xyz;
    typedef logic [2:0][CFG_W-1:0]   t_len3;

    localparam t_op OP_LOAD  = 2'd0;
    localparam t_op OP_QUERY = 2'd1;
    localparam t_op OP_CLEAR = 2'd2;

    localparam t_status ST_LOADED   = 3'd0;
    localparam t_status ST_NEIGHBOR = 3'd1;
    localparam t_status ST_NONE     = 3'd2;
    localparam t_status ST_REJECTED = 3'd3;
    localparam t_status ST_BADSLOT  = 3'd4;
    localparam t_status ST_CLEARED  = 3'd5;

    localparam t_cidx CFG_BOX_X  = 2'd0;
    localparam t_cidx CFG_BOX_Y  = 2'd1;
    localparam t_cidx CFG_BOX_Z  = 2'd2;
    localparam t_cidx CFG_CUTOFF = 2'd3;

    typedef struct packed {
        t_id  id;
        t_xyz pos;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef struct packed {
        logic  vld;
        t_slot slot;
    } t_tag;

    typedef struct packed {
        logic  vld;
        logic  hit;
        t_slot slot;
        t_id   id;
        logic  busy;
    } t_hit;

endpackage

### rtl/pnl_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pnl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/pnl_dist.sv
// Five-stage minimum-image distance pipeline: difference, wrap test,
// corrected magnitude, squares, sum against squared cutoff. Uses pnl_pkg.
module pnl_dist (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  pnl_pkg::t_tag   i_tag,
    input  pnl_pkg::t_entry i_entry,
    input  pnl_pkg::t_xyz   i_mine,
    input  pnl_pkg::t_len3  i_len,
    input  pnl_pkg::t_cfg   i_cutoff,
    output pnl_pkg::t_hit   o_hit
);
    import pnl_pkg::*;

    logic                    r1_v, r2_v, r3_v, r4_v, r5_v;
    t_slot                   r1_slot, r2_slot, r3_slot, r4_slot, r5_slot;
    t_id                     r1_id, r2_id, r3_id, r4_id, r5_id;
    logic signed [D_W-1:0]   r1_d [3];
    logic signed [D_W-1:0]   r2_d [3];
    logic [2:0]              r2_wrap;
    logic [M_W-1:0]          r3_m [3];
    logic [SQ_W-1:0]         r4_sq [3];
    logic [LIM_W-1:0]        r4_lim;
    logic                    r5_hit;

    logic signed [D_W-1:0]   n1_d [3];
    logic signed [D_W-1:0]   n2_abs [3];
    logic [2:0]              n2_wrap;
    logic signed [D_W-1:0]   n3_dc [3];
    logic signed [D_W-1:0]   n3_abs [3];
    logic [M_W-1:0]          n3_m [3];
    logic [SQ_W-1:0]         n4_sq [3];
    logic [SUM_W-1:0]        n5_sum;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n1_d[k] = signed'(D_W'(i_entry.pos[k])) - signed'(D_W'(i_mine[k]));
            n2_abs[k] = r1_d[k][D_W-1] ? -r1_d[k] : r1_d[k];
            n2_wrap[k] = {n2_abs[k][M_W-1:0], 1'b0} >= D_W'(i_len[k]);
            if (!r2_wrap[k]) begin
                n3_dc[k] = r2_d[k];
            end else if (!r2_d[k][D_W-1] && (r2_d[k] != '0)) begin
                n3_dc[k] = r2_d[k] - signed'(D_W'(i_len[k]));
            end else begin
                n3_dc[k] = r2_d[k] + signed'(D_W'(i_len[k]));
            end
            n3_abs[k] = n3_dc[k][D_W-1] ? -n3_dc[k] : n3_dc[k];
            n3_m[k] = n3_abs[k][M_W-1:0];
            n4_sq[k] = SQ_W'(r3_m[k]) * SQ_W'(r3_m[k]);
        end
        n5_sum = SUM_W'(r4_sq[0]) + SUM_W'(r4_sq[1]) + SUM_W'(r4_sq[2]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
            r5_v <= 1'b0;
        end else begin
            r1_v <= i_tag.vld;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
            r5_v <= r4_v;
        end
        r1_slot <= i_tag.slot;
        r1_id   <= i_entry.id;
        r2_slot <= r1_slot;
        r2_id   <= r1_id;
        r3_slot <= r2_slot;
        r3_id   <= r2_id;
        r4_slot <= r3_slot;
        r4_id   <= r3_id;
        r5_slot <= r4_slot;
        r5_id   <= r4_id;
        for (int k = 0; k < 3; k++) begin
            r1_d[k]  <= n1_d[k];
            r2_d[k]  <= r1_d[k];
            r3_m[k]  <= n3_m[k];
            r4_sq[k] <= n4_sq[k];
        end
        r2_wrap <= n2_wrap;
        r4_lim  <= LIM_W'(i_cutoff) * LIM_W'(i_cutoff);
        r5_hit  <= n5_sum <= SUM_W'(r4_lim);
    end

    assign o_hit.vld  = r5_v;
    assign o_hit.hit  = r5_hit;
    assign o_hit.slot = r5_slot;
    assign o_hit.id   = r5_id;
    assign o_hit.busy = r1_v | r2_v | r3_v | r4_v | r5_v;

endmodule

### rtl/periodic_neighbor_list_builder_top.sv
// Top level of the periodic neighbour list builder: control, atom store,
// config registers. Uses pnl_pkg, pnl_ram, pnl_dist.
//
//  channel  | handshake              | beat
//  ---------+------------------------+-------------------------------------
//  command  | start, busy            | op, atom id, x/y/z, query slot
//  result   | o_strobe (no stall)    | status, neighbour id/slot, last
//  config   | i_cfg_valid/o_cfg_ready| register index, data
//
// Load, clear, bad-slot query: one result the cycle after the beat, busy stays low.
// Valid query: read the named atom (S_QCAP), sweep the store with one RAM read per
// stored atom (S_SWEEP), then drain the distance pipeline (S_DRAIN); busy stays high
// throughout, and the final result comes in the same cycle that busy drops.
// Neighbour results are held one deep so the final one can carry last.
// Reset clears the atom count and config registers; no RAM clearing pass.
module periodic_neighbor_list_builder_top (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  pnl_pkg::t_op      i_op,
    input  pnl_pkg::t_id      i_atom_id,
    input  pnl_pkg::t_coord   i_pos_x,
    input  pnl_pkg::t_coord   i_pos_y,
    input  pnl_pkg::t_coord   i_pos_z,
    input  pnl_pkg::t_slot    i_query_slot,
    output logic              o_strobe,
    output pnl_pkg::t_status  o_status,
    output pnl_pkg::t_id      o_neighbor_id,
    output pnl_pkg::t_slot    o_neighbor_slot,
    output logic              o_last,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  pnl_pkg::t_cidx    i_cfg_index,
    input  pnl_pkg::t_cfg     i_cfg_data
);
    import pnl_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_QCAP  = 2'd1;
    localparam logic [1:0] S_SWEEP = 2'd2;
    localparam logic [1:0] S_DRAIN = 2'd3;

    logic [1:0] r_state, n_state;
    t_cnt       r_cnt, n_cnt;
    t_slot      r_a, n_a;
    t_slot      r_b, n_b;
    t_xyz       r_mine, n_mine;
    t_len3      r_len;
    t_cfg       r_cut;
    t_tag       r_iss, n_iss;
    logic       r_pv, n_pv;
    t_id        r_pend_id, n_pend_id;
    t_slot      r_pend_slot, n_pend_slot;
    logic       r_strb, n_strb;
    t_status    r_status, n_status;
    t_id        r_nid, n_nid;
    t_slot      r_nslot, n_nslot;
    logic       r_last, n_last;

    logic       accept;
    logic       load_ok;
    logic       ram_we;
    t_slot      ram_raddr;
    t_entry     wr_entry;
    t_entry     rd_entry;
    t_hit       hit;

    assign busy        = r_state != S_IDLE;
    assign o_cfg_ready = 1'b1;
    assign accept      = start & ~busy;

    assign load_ok = (r_cnt != CNT_W'(MAX_ATOMS))
                   && (V_W'(i_pos_x) < V_W'(r_len[0]))
                   && (V_W'(i_pos_y) < V_W'(r_len[1]))
                   && (V_W'(i_pos_z) < V_W'(r_len[2]));

    assign ram_we       = accept && (i_op == OP_LOAD) && load_ok;
    assign ram_raddr    = (r_state == S_IDLE) ? i_query_slot : r_b;
    assign wr_entry.id  = i_atom_id;
    assign wr_entry.pos = {i_pos_z, i_pos_y, i_pos_x};

    pnl_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_ATOMS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_cnt[SLOT_W-1:0]),
        .i_wdata (wr_entry),
        .i_raddr (ram_raddr),
        .o_rdata (rd_entry)
    );

    pnl_dist u_dist (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tag    (r_iss),
        .i_entry  (rd_entry),
        .i_mine   (r_mine),
        .i_len    (r_len),
        .i_cutoff (r_cut),
        .o_hit    (hit)
    );

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_a         = r_a;
        n_b         = r_b;
        n_mine      = r_mine;
        n_iss       = '0;
        n_pv        = r_pv;
        n_pend_id   = r_pend_id;
        n_pend_slot = r_pend_slot;
        n_strb      = 1'b0;
        n_status    = r_status;
        n_nid       = r_nid;
        n_nslot     = r_nslot;
        n_last      = r_last;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_op)
                        OP_LOAD: begin
                            n_strb   = 1'b1;
                            n_status = load_ok ? ST_LOADED : ST_REJECTED;
                            n_nid    = '0;
                            n_nslot  = '0;
                            n_last   = 1'b1;
                            if (load_ok) begin
                                n_cnt = r_cnt + CNT_W'(1);
                            end
                        end
                        OP_QUERY: begin
                            if (CNT_W'(i_query_slot) >= r_cnt) begin
                                n_strb   = 1'b1;
                                n_status = ST_BADSLOT;
                                n_nid    = '0;
                                n_nslot  = '0;
                                n_last   = 1'b1;
                            end else begin
                                n_a     = i_query_slot;
                                n_pv    = 1'b0;
                                n_state = S_QCAP;
                            end
                        end
                        OP_CLEAR: begin
                            n_cnt    = '0;
                            n_strb   = 1'b1;
                            n_status = ST_CLEARED;
                            n_nid    = '0;
                            n_nslot  = '0;
                            n_last   = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_QCAP: begin
                n_mine  = rd_entry.pos;
                n_b     = '0;
                n_state = S_SWEEP;
            end
            S_SWEEP: begin
                n_iss.vld  = 1'b1;
                n_iss.slot = r_b;
                n_b        = r_b + SLOT_W'(1);
                if (CNT_W'({1'b0, r_b}) + CNT_W'(1) == r_cnt) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!r_iss.vld && !hit.busy) begin
                    n_strb  = 1'b1;
                    n_last  = 1'b1;
                    if (r_pv) begin
                        n_status = ST_NEIGHBOR;
                        n_nid    = r_pend_id;
                        n_nslot  = r_pend_slot;
                    end else begin
                        n_status = ST_NONE;
                        n_nid    = '0;
                        n_nslot  = '0;
                    end
                    n_pv    = 1'b0;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // earlier pending neighbour goes out once a later one is found
        if (hit.vld && hit.hit && (hit.slot != r_a)) begin
            if (r_pv) begin
                n_strb   = 1'b1;
                n_status = ST_NEIGHBOR;
                n_nid    = r_pend_id;
                n_nslot  = r_pend_slot;
                n_last   = 1'b0;
            end
            n_pv        = 1'b1;
            n_pend_id   = hit.id;
            n_pend_slot = hit.slot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_iss   <= '0;
            r_pv    <= 1'b0;
            r_strb  <= 1'b0;
            r_len   <= {3{{CFG_W{1'b1}}}};
            r_cut   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_iss   <= n_iss;
            r_pv    <= n_pv;
            r_strb  <= n_strb;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_BOX_X:  r_len[0] <= i_cfg_data;
                    CFG_BOX_Y:  r_len[1] <= i_cfg_data;
                    CFG_BOX_Z:  r_len[2] <= i_cfg_data;
                    CFG_CUTOFF: r_cut    <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
        r_a         <= n_a;
        r_b         <= n_b;
        r_mine      <= n_mine;
        r_pend_id   <= n_pend_id;
        r_pend_slot <= n_pend_slot;
        r_status    <= n_status;
        r_nid       <= n_nid;
        r_nslot     <= n_nslot;
        r_last      <= n_last;
    end

    assign o_strobe        = r_strb;
    assign o_status        = r_status;
    assign o_neighbor_id   = r_nid;
    assign o_neighbor_slot = r_nslot;
    assign o_last          = r_last;

endmodule

### sim/periodic_neighbor_list_builder_top_test.sv
// Self-checking testbench for periodic_neighbor_list_builder_top: loads, queries and clears
// under random bursts and gaps, with a scoreboard class that predicts every result beat.
// Depends on rtl/pnl_pkg.sv and the RTL of the top level.
`timescale 1ns / 1ps

module periodic_neighbor_list_builder_top_test;

    import pnl_pkg::*;

    localparam t_op    OP_SPARE    = 2'd3;
    localparam t_cfg   CFG_MAX     = '1;
    localparam t_coord COORD_MAX   = '1;
    localparam t_id    ID_MAX      = '1;
    localparam int     SETTLE_CYC  = 80;

    class neighbor_list_scoreboard;
        typedef struct {
            t_status status;
            t_id     id;
            t_slot   slot;
            logic    last;
        } t_result;

        t_id     atom_id  [MAX_ATOMS];
        t_coord  atom_pos [MAX_ATOMS][3];
        int      stored_count;
        t_cfg    box_len [3];
        t_cfg    cutoff;
        t_result pending_results [$];
        int      mismatch_count;

        function new();
            foreach (box_len[k]) box_len[k] = CFG_MAX;
            cutoff         = '0;
            stored_count   = 0;
            mismatch_count = 0;
        endfunction

        function void write_register(t_cidx idx, t_cfg data);
            case (idx)
                CFG_BOX_X:  box_len[0] = data;
                CFG_BOX_Y:  box_len[1] = data;
                CFG_BOX_Z:  box_len[2] = data;
                CFG_CUTOFF: cutoff     = data;
                default: ;
            endcase
        endfunction

        function void queue_result(t_status st, t_id id, t_slot slot, logic last);
            t_result r;
            r.status = st;
            r.id     = id;
            r.slot   = slot;
            r.last   = last;
            pending_results = {pending_results, r};
        endfunction

        // one shift of a box length per axis, applied even if coords now lie outside the box
        function longint image_sq(t_coord other, t_coord mine, t_cfg len);
            longint d, l;
            d = longint'(other) - longint'(mine);
            l = longint'(len);
            if (2 * (d < 0 ? -d : d) >= l) begin
                d = (d > 0) ? d - l : d + l;
            end
            return d * d;
        endfunction

        function bit in_range(int a, int b);
            longint sum, c;
            sum = 0;
            for (int k = 0; k < 3; k++) begin
                sum += image_sq(atom_pos[b][k], atom_pos[a][k], box_len[k]);
            end
            c = longint'(cutoff);
            return sum <= c * c;
        endfunction

        function void record_command(t_op op, t_id id, t_coord x, t_coord y, t_coord z,
                                     t_slot slot);
            bit hit [MAX_ATOMS];
            int last_hit;
            last_hit = -1;
            case (op)
                OP_LOAD: begin
                    if (stored_count >= MAX_ATOMS || x >= box_len[0] || y >= box_len[1] ||
                        z >= box_len[2]) begin
                        queue_result(ST_REJECTED, '0, '0, 1'b1);
                    end else begin
                        atom_id[stored_count]     = id;
                        atom_pos[stored_count][0] = x;
                        atom_pos[stored_count][1] = y;
                        atom_pos[stored_count][2] = z;
                        stored_count++;
                        queue_result(ST_LOADED, '0, '0, 1'b1);
                    end
                end
                OP_QUERY: begin
                    if (int'(slot) >= stored_count) begin
                        queue_result(ST_BADSLOT, '0, '0, 1'b1);
                    end else begin
                        for (int b = 0; b < stored_count; b++) begin
                            hit[b] = (b != int'(slot)) && in_range(int'(slot), b);
                            if (hit[b]) last_hit = b;
                        end
                        if (last_hit < 0) begin
                            queue_result(ST_NONE, '0, '0, 1'b1);
                        end else begin
                            for (int b = 0; b <= last_hit; b++) begin
                                if (hit[b]) begin
                                    queue_result(ST_NEIGHBOR, atom_id[b], t_slot'(b),
                                                 logic'(b == last_hit));
                                end
                            end
                        end
                    end
                end
                OP_CLEAR: begin
                    stored_count = 0;
                    queue_result(ST_CLEARED, '0, '0, 1'b1);
                end
                default: ;
            endcase
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                mismatch_count++;
            end
        endfunction

        function void check_result(t_status st, t_id id, t_slot slot, logic last);
            t_result want;
            if (pending_results.size() == 0) begin
                $error("result beat with nothing outstanding: status %0d id %0d slot %0d",
                       st, id, slot);
                mismatch_count++;
                return;
            end
            want = pending_results.pop_front();
            compare_field("status", 32'(want.status), 32'(st));
            compare_field("neighbor_id", 32'(want.id), 32'(id));
            compare_field("neighbor_slot", 32'(want.slot), 32'(slot));
            compare_field("last", 32'(want.last), 32'(last));
        endfunction
    endclass

    logic     i_clk = 1'b0;
    logic     i_rst_n;
    logic     start;
    logic     busy;
    t_op      i_op;
    t_id      i_atom_id;
    t_coord   i_pos_x;
    t_coord   i_pos_y;
    t_coord   i_pos_z;
    t_slot    i_query_slot;
    logic     o_strobe;
    t_status  o_status;
    t_id      o_neighbor_id;
    t_slot    o_neighbor_slot;
    logic     o_last;
    logic     i_cfg_valid;
    logic     o_cfg_ready;
    t_cidx    i_cfg_index;
    t_cfg     i_cfg_data;

    neighbor_list_scoreboard sb = new();
    int burst_left;

    periodic_neighbor_list_builder_top i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_op            (i_op),
        .i_atom_id       (i_atom_id),
        .i_pos_x         (i_pos_x),
        .i_pos_y         (i_pos_y),
        .i_pos_z         (i_pos_z),
        .i_query_slot    (i_query_slot),
        .o_strobe        (o_strobe),
        .o_status        (o_status),
        .o_neighbor_id   (o_neighbor_id),
        .o_neighbor_slot (o_neighbor_slot),
        .o_last          (o_last),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_strobe) begin
                sb.check_result(o_status, o_neighbor_id, o_neighbor_slot, o_last);
            end
            if (start && !busy) begin
                sb.record_command(i_op, i_atom_id, i_pos_x, i_pos_y, i_pos_z, i_query_slot);
            end
        end
    end

    task automatic wait_empty();
        @(posedge i_clk);
        while (sb.pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic send(t_op op, t_id id, t_coord x, t_coord y, t_coord z, t_slot slot);
        start        <= 1'b1;
        i_op         <= op;
        i_atom_id    <= id;
        i_pos_x      <= x;
        i_pos_y      <= y;
        i_pos_z      <= z;
        i_query_slot <= slot;
        do @(posedge i_clk); while (busy);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            start <= 1'b0;
            if ($urandom_range(0, 31) == 0) begin
                wait_empty();
            end else begin
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
            end
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(0, 10);
        end
    endtask

    task automatic settle();
        start <= 1'b0;
        wait_empty();
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    task automatic load_atom(t_id id, t_coord x, t_coord y, t_coord z);
        send(OP_LOAD, id, x, y, z, t_slot'($urandom));
    endtask

    task automatic query_atom(t_slot slot);
        send(OP_QUERY, t_id'($urandom), t_coord'($urandom), t_coord'($urandom),
             t_coord'($urandom), slot);
    endtask

    task automatic clear_store();
        send(OP_CLEAR, t_id'($urandom), t_coord'($urandom), t_coord'($urandom),
             t_coord'($urandom), t_slot'($urandom));
    endtask

    task automatic send_spare();
        send(OP_SPARE, t_id'($urandom), t_coord'($urandom), t_coord'($urandom),
             t_coord'($urandom), t_slot'($urandom));
    endtask

    task automatic write_reg(t_cidx idx, t_cfg data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_register(idx, data);
    endtask

    task automatic configure(t_cfg bx, t_cfg by, t_cfg bz, t_cfg cut);
        write_reg(CFG_BOX_X, bx);
        write_reg(CFG_BOX_Y, by);
        write_reg(CFG_BOX_Z, bz);
        write_reg(CFG_CUTOFF, cut);
        i_cfg_valid <= 1'b0;
    endtask

    // mostly in-box, some copies of stored positions (zero distance), some shared ids, some rejects
    task automatic random_load();
        t_coord p [3];
        t_id    id;
        int     r, axis, src;
        r    = $urandom_range(0, 99);
        axis = $urandom_range(0, 2);
        src  = (sb.stored_count > 0) ? $urandom_range(0, sb.stored_count - 1) : 0;
        id   = t_id'($urandom);
        for (int k = 0; k < 3; k++) begin
            p[k] = t_coord'($urandom_range(0, int'(sb.box_len[k]) - 1));
        end
        if (r < 8) begin
            p[axis] = t_coord'($urandom_range(int'(sb.box_len[axis]), int'(COORD_MAX)));
        end else if (r < 22 && sb.stored_count > 0) begin
            for (int k = 0; k < 3; k++) p[k] = sb.atom_pos[src][k];
        end
        if ($urandom_range(0, 9) == 0 && sb.stored_count > 0) id = sb.atom_id[src];
        load_atom(id, p[0], p[1], p[2]);
    endtask

    task automatic random_query(int count);
        if (count == 0 || $urandom_range(0, 9) == 0) begin
            query_atom(t_slot'($urandom_range(0, MAX_ATOMS - 1)));
        end else begin
            query_atom(t_slot'($urandom_range(0, count - 1)));
        end
    endtask

    task automatic run_phase(int target, bit fill);
        int sent, n_loads;
        sent = 0;
        // store still holds atoms loaded under the previous settings
        repeat ($urandom_range(1, 3)) begin
            random_query(sb.stored_count);
            sent++;
        end
        while (sent < target) begin
            clear_store();
            sent++;
            if (fill) n_loads = MAX_ATOMS + 2;
            else if ($urandom_range(0, 3) == 0) n_loads = $urandom_range(20, 40);
            else n_loads = $urandom_range(0, 12);
            fill = 1'b0;
            repeat (n_loads) begin
                random_load();
                sent++;
                if ($urandom_range(0, 19) == 0) send_spare();
            end
            repeat ($urandom_range(2, 8)) begin
                random_query((n_loads > MAX_ATOMS) ? MAX_ATOMS : n_loads);
                sent++;
            end
        end
    endtask

    initial begin
        #5_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        t_cfg bx, by, bz, cut;
        i_rst_n      <= 1'b0;
        start        <= 1'b0;
        i_op         <= OP_LOAD;
        i_atom_id    <= '0;
        i_pos_x      <= '0;
        i_pos_y      <= '0;
        i_pos_z      <= '0;
        i_query_slot <= '0;
        i_cfg_valid  <= 1'b0;
        i_cfg_index  <= CFG_BOX_X;
        i_cfg_data   <= '0;
        burst_left   = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: full box, zero cutoff
        query_atom('0);
        send_spare();
        load_atom('0, '0, '0, '0);
        load_atom(ID_MAX, COORD_MAX - t_coord'(1), COORD_MAX - t_coord'(1),
                  COORD_MAX - t_coord'(1));
        load_atom(t_id'(20'd5), COORD_MAX, '0, '0);
        load_atom(t_id'(20'd6), '0, COORD_MAX, '0);
        load_atom(t_id'(20'd7), '0, '0, COORD_MAX);
        query_atom('0);
        load_atom('0, '0, '0, '0);
        query_atom('0);
        query_atom(t_slot'(2));
        query_atom(t_slot'(3));
        query_atom('1);
        clear_store();
        query_atom('0);
        settle();

        // even box: half-box ties and wrap across faces
        configure(t_cfg'(20'd1000), t_cfg'(20'd1000), t_cfg'(20'd1000), t_cfg'(20'd500));
        load_atom(t_id'(20'd7), '0, '0, '0);
        load_atom(t_id'(20'd8), t_coord'(20'd500), '0, '0);
        load_atom(t_id'(20'd9), t_coord'(20'd999), t_coord'(20'd999), t_coord'(20'd999));
        load_atom(t_id'(20'd10), '0, t_coord'(20'd501), '0);
        query_atom('0);
        query_atom(t_slot'(1));
        query_atom(t_slot'(3));
        settle();

        for (int phase = 0; phase < 8; phase++) begin
            case (phase)
                0: begin
                    bx = CFG_MAX; by = CFG_MAX; bz = CFG_MAX; cut = CFG_MAX;
                end
                1: begin
                    bx  = t_cfg'($urandom_range(64, 4096));
                    by  = t_cfg'($urandom_range(64, 4096));
                    bz  = t_cfg'($urandom_range(64, 4096));
                    cut = t_cfg'($urandom_range(0, 2048));
                end
                2: begin
                    bx = t_cfg'(1); by = t_cfg'(1); bz = t_cfg'(1); cut = '0;
                end
                3: begin
                    bx = CFG_MAX; by = CFG_MAX; bz = CFG_MAX;
                    cut = t_cfg'($urandom_range(0, int'(CFG_MAX)));
                end
                4: begin
                    bx  = t_cfg'($urandom_range(1, int'(CFG_MAX)));
                    by  = t_cfg'($urandom_range(1, int'(CFG_MAX)));
                    bz  = t_cfg'($urandom_range(1, int'(CFG_MAX)));
                    cut = t_cfg'($urandom_range(0, int'(CFG_MAX)));
                end
                5: begin
                    bx  = t_cfg'($urandom_range(2, 64));
                    by  = t_cfg'($urandom_range(2, 64));
                    bz  = t_cfg'($urandom_range(2, 64));
                    cut = CFG_MAX;
                end
                6: begin
                    bx  = t_cfg'($urandom_range(1, int'(CFG_MAX)));
                    by  = t_cfg'($urandom_range(1, int'(CFG_MAX)));
                    bz  = t_cfg'($urandom_range(1, int'(CFG_MAX)));
                    cut = '0;
                end
                default: begin
                    bx  = t_cfg'($urandom_range(256, 2048));
                    by  = t_cfg'($urandom_range(256, 2048));
                    bz  = t_cfg'($urandom_range(256, 2048));
                    cut = t_cfg'($urandom_range(100, 2048));
                end
            endcase
            configure(bx, by, bz, cut);
            run_phase(35, phase == 0 || phase == 5);
            settle();
        end

        if (sb.mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

### files.f
rtl/pnl_pkg.sv
rtl/pnl_ram.sv
rtl/pnl_dist.sv
rtl/periodic_neighbor_list_builder_top.sv
sim/periodic_neighbor_list_builder_top_test.sv
